// ===== src/brf_pkg.sv =====
package brf_pkg;

  // Fixed-point formats: interval ends Q8.24 in 32 bits, polynomial values Q.24 in 48 bits.
  localparam int unsigned XW   = 32;
  localparam int unsigned FW   = 48;
  localparam int unsigned TOLW = 25;
  localparam int unsigned ITW  = 7;
  localparam int unsigned CIW  = 1;

  // Register indexes on the configuration port.
  localparam logic [CIW-1:0] CFG_TOLERANCE  = 1'b0;
  localparam logic [CIW-1:0] CFG_ITER_LIMIT = 1'b1;

  localparam logic [TOLW-1:0] TOL_RESET   = 25'd17;
  localparam logic [ITW-1:0]  LIMIT_RESET = 7'd50;
  localparam logic [ITW-1:0]  LIMIT_MAX   = 7'd64;

  // Constant term of the polynomial, 10.0 in Q.24.
  localparam logic signed [FW-1:0] TEN_Q24 = 48'sd167772160;

  typedef enum logic [1:0] {
    ST_CONT   = 2'd0,
    ST_ROOT   = 2'd1,
    ST_NOROOT = 2'd2,
    ST_LIMIT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TGT_A,
    TGT_B,
    TGT_C
  } tgt_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_HI,
    OP_SQ_LO,
    OP_CU_HI,
    OP_CU_LO,
    OP_SUM,
    OP_MID,
    OP_STEP
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    tgt_e    tgt;
    logic    emit;
    status_e status;
    logic    last;
  } dp_cmd_t;

  typedef struct packed {
    logic sign_ab;
    logic sign_ac;
    logic root;
    logic at_limit;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/brf_ctrl.sv =====
module brf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brf_pkg::dp_stat_t stat_i,
  output brf_pkg::dp_cmd_t  cmd_o
);
  import brf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_HI,
    S_SQ_LO,
    S_CU_HI,
    S_CU_LO,
    S_SUM,
    S_SIGN,
    S_ROW,
    S_MID
  } state_e;

  state_e state_q, state_d;
  tgt_e   tgt_q, tgt_d;

  always_comb begin
    state_d    = state_q;
    tgt_d      = tgt_q;
    cmd_o      = '{op: OP_NONE, tgt: tgt_q, emit: 1'b0, status: ST_CONT, last: 1'b0};
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          tgt_d    = TGT_A;
          state_d  = S_SQ_HI;
        end
      end
      S_SQ_HI: begin
        cmd_o.op = OP_SQ_HI;
        state_d  = S_SQ_LO;
      end
      S_SQ_LO: begin
        cmd_o.op = OP_SQ_LO;
        state_d  = S_CU_HI;
      end
      S_CU_HI: begin
        cmd_o.op = OP_CU_HI;
        state_d  = S_CU_LO;
      end
      S_CU_LO: begin
        cmd_o.op = OP_CU_LO;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        unique case (tgt_q)
          TGT_A: begin
            tgt_d   = TGT_B;
            state_d = S_SQ_HI;
          end
          TGT_B:   state_d = S_SIGN;
          default: state_d = S_ROW;
        endcase
      end
      S_SIGN: begin
        if (!stat_i.sign_ab) begin
          if (stat_i.out_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_NOROOT;
            cmd_o.last   = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.op = OP_MID;
          tgt_d    = TGT_C;
          state_d  = S_SQ_HI;
        end
      end
      S_ROW: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.root) begin
            cmd_o.status = ST_ROOT;
            cmd_o.last   = 1'b1;
            state_d      = S_IDLE;
          end else if (stat_i.at_limit) begin
            cmd_o.status = ST_LIMIT;
            cmd_o.last   = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cmd_o.op = OP_STEP;
            state_d  = S_MID;
          end
        end
      end
      S_MID: begin
        cmd_o.op = OP_MID;
        state_d  = S_SQ_HI;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tgt_q   <= TGT_A;
    end else begin
      state_q <= state_d;
      tgt_q   <= tgt_d;
    end
  end

endmodule

// ===== src/brf_datapath.sv =====
module brf_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [brf_pkg::XW-1:0]     left_end_i,
  input  logic signed [brf_pkg::XW-1:0]     right_end_i,
  input  logic        [brf_pkg::TOLW-1:0]   tol_i,
  input  logic        [brf_pkg::ITW-1:0]    limit_i,
  input  brf_pkg::dp_cmd_t                  cmd_i,
  output brf_pkg::dp_stat_t                 stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic        [brf_pkg::ITW-1:0]    iteration_o,
  output logic signed [brf_pkg::XW-1:0]     lower_bound_o,
  output logic signed [brf_pkg::XW-1:0]     upper_bound_o,
  output logic signed [brf_pkg::XW-1:0]     midpoint_o,
  output logic signed [brf_pkg::FW-1:0]     f_lower_o,
  output logic signed [brf_pkg::FW-1:0]     f_upper_o,
  output logic signed [brf_pkg::FW-1:0]     f_mid_o,
  output logic        [1:0]                 status_o,
  output logic                              last_o
);
  import brf_pkg::*;

  logic signed [XW-1:0] a_q, b_q, c_q, x_q;
  logic signed [FW-1:0] fa_q, fb_q, fc_q;
  logic signed [39:0]   x2_q;
  logic signed [71:0]   acc_q;
  logic [ITW-1:0]       iter_q;
  logic                 out_valid_q;

  logic signed [39:0] mul_a;
  logic signed [16:0] mul_d;
  logic signed [56:0] prod;
  logic signed [71:0] prod_ext;
  logic signed [FW-1:0] poly;
  logic signed [XW:0]   sum_ab;
  logic signed [XW-1:0] mid;
  logic [FW-1:0]        mag_c;
  logic [ITW-1:0]       eff_limit;

  function automatic logic opposite(input logic signed [FW-1:0] p,
                                    input logic signed [FW-1:0] q);
    logic p_pos, p_neg, q_pos, q_neg;
    p_neg = p[FW-1];
    q_neg = q[FW-1];
    p_pos = !p[FW-1] && (p != '0);
    q_pos = !q[FW-1] && (q != '0);
    return (p_pos && q_neg) || (p_neg && q_pos);
  endfunction

  // Shared multiplier: 40-bit operand times a 16-bit x digit (high signed), two digits a product.
  always_comb begin
    case (cmd_i.op) inside
      OP_SQ_HI, OP_SQ_LO: mul_a = {{8{x_q[XW-1]}}, x_q};
      OP_CU_HI:           mul_a = acc_q[63:24];
      default:            mul_a = x2_q;
    endcase
    if (cmd_i.op == OP_SQ_HI || cmd_i.op == OP_CU_HI) begin
      mul_d = {x_q[XW-1], x_q[31:16]};
    end else begin
      mul_d = {1'b0, x_q[15:0]};
    end
  end

  assign prod     = mul_a * mul_d;
  assign prod_ext = {{15{prod[56]}}, prod};

  assign poly   = acc_q[71:24] + {{6{x2_q[39]}}, x2_q, 2'b00} - TEN_Q24;
  assign sum_ab = {a_q[XW-1], a_q} + {b_q[XW-1], b_q};
  assign mid    = sum_ab[XW:1];
  assign mag_c  = fc_q[FW-1] ? (~fc_q + 1'b1) : fc_q;

  always_comb begin
    if (limit_i == '0) begin
      eff_limit = 7'd1;
    end else if (limit_i > LIMIT_MAX) begin
      eff_limit = LIMIT_MAX;
    end else begin
      eff_limit = limit_i;
    end
  end

  assign stat_o.sign_ab  = opposite(fa_q, fb_q);
  assign stat_o.sign_ac  = opposite(fa_q, fc_q);
  assign stat_o.root     = mag_c < {{(FW-TOLW){1'b0}}, tol_i};
  assign stat_o.at_limit = iter_q == eff_limit;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op) inside
      OP_LOAD: begin
        a_q    <= left_end_i;
        b_q    <= right_end_i;
        x_q    <= left_end_i;
        iter_q <= 7'd1;
      end
      OP_SQ_HI: acc_q <= prod_ext;
      OP_CU_HI: begin
        acc_q <= prod_ext;
        x2_q  <= acc_q[63:24];
      end
      OP_SQ_LO, OP_CU_LO: acc_q <= (acc_q <<< 16) + prod_ext;
      OP_SUM: begin
        case (cmd_i.tgt)
          TGT_A: begin
            fa_q <= poly;
            x_q  <= b_q;
          end
          TGT_B:   fb_q <= poly;
          default: fc_q <= poly;
        endcase
      end
      OP_MID: begin
        c_q <= mid;
        x_q <= mid;
      end
      OP_STEP: begin
        if (stat_o.sign_ac) begin
          b_q  <= c_q;
          fb_q <= fc_q;
        end else begin
          a_q  <= c_q;
          fa_q <= fc_q;
        end
        iter_q <= iter_q + 7'd1;
      end
      default: ;
    endcase
  end

  // Result register: a no-root row carries iteration, midpoint and f_mid as zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      lower_bound_o <= a_q;
      upper_bound_o <= b_q;
      f_lower_o     <= fa_q;
      f_upper_o     <= fb_q;
      status_o      <= cmd_i.status;
      last_o        <= cmd_i.last;
      if (cmd_i.status == ST_NOROOT) begin
        iteration_o <= '0;
        midpoint_o  <= '0;
        f_mid_o     <= '0;
      end else begin
        iteration_o <= iter_q;
        midpoint_o  <= c_q;
        f_mid_o     <= fc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/bisection_root_finder_core.sv =====
// Channel | Direction | Handshake                | Payload
// --------+-----------+--------------------------+-----------------------------------------
// input   | in        | in_valid_i / in_ready_o  | left_end_i, right_end_i
// result  | out       | out_valid_o / out_ready_i| iteration_o .. f_mid_o, status_o, last_o
// config  | in        | cfg_we_i (no wait)       | cfg_index_i, cfg_data_i
//
// One interval is handled at a time. Each polynomial value is built on the shared 40 x 17 bit
// multiplier in two digit steps each for x*x and x2*x, then the final sum. After the input
// transfer f(a) and f(b) are formed and their signs checked; a no-root row follows that check,
// while each other row follows a midpoint and its polynomial value. Reset clears the controller
// and the result valid flag; tolerance resets to 17, the limit to 50. A stalled result register
// holds the run at the next row; input is taken again once the last row has been loaded.
module bisection_root_finder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [brf_pkg::XW-1:0]     left_end_i,
  input  logic signed [brf_pkg::XW-1:0]     right_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic        [brf_pkg::ITW-1:0]    iteration_o,
  output logic signed [brf_pkg::XW-1:0]     lower_bound_o,
  output logic signed [brf_pkg::XW-1:0]     upper_bound_o,
  output logic signed [brf_pkg::XW-1:0]     midpoint_o,
  output logic signed [brf_pkg::FW-1:0]     f_lower_o,
  output logic signed [brf_pkg::FW-1:0]     f_upper_o,
  output logic signed [brf_pkg::FW-1:0]     f_mid_o,
  output logic        [1:0]                 status_o,
  output logic                              last_o,
  input  logic                              cfg_we_i,
  input  logic        [brf_pkg::CIW-1:0]    cfg_index_i,
  input  logic        [brf_pkg::TOLW-1:0]   cfg_data_i
);
  import brf_pkg::*;

  logic [TOLW-1:0] tol_q;
  logic [ITW-1:0]  limit_q;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  // Configuration registers. The limit keeps its raw value; the datapath clamps it to 1..64.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= TOL_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TOLERANCE:  tol_q   <= cfg_data_i;
        CFG_ITER_LIMIT: limit_q <= cfg_data_i[ITW-1:0];
        default: ;
      endcase
    end
  end

  brf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  brf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .left_end_i    (left_end_i),
    .right_end_i   (right_end_i),
    .tol_i         (tol_q),
    .limit_i       (limit_q),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .iteration_o   (iteration_o),
    .lower_bound_o (lower_bound_o),
    .upper_bound_o (upper_bound_o),
    .midpoint_o    (midpoint_o),
    .f_lower_o     (f_lower_o),
    .f_upper_o     (f_upper_o),
    .f_mid_o       (f_mid_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule
